FILE: sv/rrlb_pkg.sv
// Types, constants and register codes for the radial ripple LED blend block.
// No dependencies; imported by every module of the block.
`default_nettype none

package rrlb_pkg;

   localparam int BAND_WIDTH = 36;
   localparam int FRAC_BITS  = 6;

   localparam int X_W   = 9;
   localparam int Y_W   = 8;
   localparam int CH_W  = 8;
   localparam int RGB_W = 3 * CH_W;
   localparam int LIMIT_W = 15;
   localparam int STEP_W  = 12;
   localparam int CSR_IDX_W = 3;

   localparam int BAND   = BAND_WIDTH << FRAC_BITS;
   localparam int BAND_W = $clog2(BAND + 1);

   localparam int RADIUS_W = (BAND_W + 1 > 16) ? BAND_W + 1 : 16;

   // dx^2 + dy^2, then shifted left by 2*FRAC_BITS bits before the root
   localparam int SUM_W      = 2 * X_W + 1;
   localparam int RAW_W      = SUM_W + 2 * FRAC_BITS;
   localparam int ROOT_W     = (RAW_W + 1) / 2;
   localparam int RADICAND_W = 2 * ROOT_W;
   localparam int ROOT_CNT_W = $clog2(ROOT_W);

   localparam int DIFF_W = ((ROOT_W > RADIUS_W) ? ROOT_W : RADIUS_W) + 2;

   // blend numerator and reciprocal for the divide by BAND
   localparam int NUM_W   = BAND_W + CH_W;
   localparam int PROD_W  = BAND_W + CH_W + 2;
   localparam int RECIP   = (2 ** NUM_W) / BAND;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int QPROD_W = NUM_W + RECIP_W;

   localparam logic [RGB_W-1:0]    FG_RESET     = 24'hFF_FFFF;
   localparam logic [RGB_W-1:0]    BG_RESET     = 24'hFF_FFFF;
   localparam logic [X_W-1:0]      CX_RESET     = 9'd149;
   localparam logic [Y_W-1:0]      CY_RESET     = 8'd38;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 15'd13917;
   localparam logic [STEP_W-1:0]   STEP_RESET   = 12'd270;

   typedef enum logic {
      OP_KEY  = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FOREGROUND = 3'd0,
      CSR_BACKGROUND = 3'd1,
      CSR_CENTER_X   = 3'd2,
      CSR_CENTER_Y   = 3'd3,
      CSR_RING_LIMIT = 3'd4,
      CSR_RING_STEP  = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_ROOT_GO,
      ST_ROOT,
      ST_DIFF,
      ST_MIX,
      ST_QUOT,
      ST_FIX
   } state_type;

   typedef struct packed {
      op_type         op;
      logic [X_W-1:0] key_x;
      logic [Y_W-1:0] key_y;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            in_band;
   } rsp_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } root_result_type;

endpackage

`default_nettype wire

FILE: sv/rrlb_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on rrlb_pkg.
`default_nettype none

module rrlb_sqrt (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [rrlb_pkg::RADICAND_W-1:0] radicand,
   output rrlb_pkg::root_result_type            result
);
   import rrlb_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [ROOT_CNT_W-1:0] count_ff;
   logic [RADICAND_W-1:0] val_ff;
   logic [ROOT_W+1:0]     rem_ff;
   logic [ROOT_W-1:0]     root_ff;

   logic [ROOT_W+1:0] shifted;
   logic [ROOT_W+1:0] trial;
   logic              take;
   logic              last;

   assign shifted = {rem_ff[ROOT_W-1:0], val_ff[RADICAND_W-1 -: 2]};
   assign trial   = {root_ff, 2'b01};
   assign take    = shifted >= trial;
   assign last    = count_ff == ROOT_CNT_W'(ROOT_W - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= busy_ff & last;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + ROOT_CNT_W'(1);
            if (last) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         val_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         val_ff <= {val_ff[RADICAND_W-3:0], 2'b00};
         if (take) begin
            rem_ff  <= shifted - trial;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= shifted;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign result.done = done_ff;
   assign result.root = root_ff;

endmodule

`default_nettype wire

FILE: sv/radial_ripple_led_blend.sv
// Radial ripple LED blend: distance from centre, ring band test, color blend.
// Depends on rrlb_pkg and rrlb_sqrt.
//
//   channel  ports                          direction  moves
//   req      req_valid req_stall req_data   in         op, key_x, key_y
//   rsp      rsp_valid rsp_stall rsp_data   out        red, green, blue, in_band
//   csr      csr_we csr_index csr_wdata     in         register writes
//
// A key transfer holds req_stall high through ST_SQ_X and ST_SQ_Y (square and sum),
// ST_ROOT_GO and ST_ROOT (16 root iterations and the done flag), then ST_DIFF, ST_MIX,
// ST_QUOT and ST_FIX (blend, divide and load); no new transfer is taken until then.
// A tick transfer updates the ring radius and leaves req_stall low.
// A stalled rsp holds back the load of the next result and keeps req_stall high.
// Reset is synchronous and restores the configuration registers and the ring radius.
`default_nettype none

module radial_ripple_led_blend (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire rrlb_pkg::req_type              req_data,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      rrlb_pkg::rsp_type              rsp_data,
   input  wire logic                           csr_we,
   input  wire logic [rrlb_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rrlb_pkg::RGB_W-1:0]     csr_wdata
);
   import rrlb_pkg::*;

   state_type state_ff, state_in;

   logic [RGB_W-1:0]   fg_ff;
   logic [RGB_W-1:0]   bg_ff;
   logic [X_W-1:0]     cx_ff;
   logic [Y_W-1:0]     cy_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic [STEP_W-1:0]  step_ff;

   logic signed [RADIUS_W-1:0] radius_ff, radius_in;
   logic signed [RADIUS_W:0]   radius_sum;

   logic [X_W-1:0]   ax_ff;
   logic [Y_W-1:0]   ay_ff;
   logic [SUM_W-1:0] sq_ff;
   logic [X_W-1:0]   mul_op;
   logic [2*X_W-1:0] mul_out;

   logic            root_start;
   root_result_type root_res;

   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]        mag;
   logic                     band_hit;
   logic [BAND_W-1:0]        a_ff;
   logic                     in_band_ff;

   logic [NUM_W-1:0] num_ff [3];
   logic [CH_W-1:0]  q0_ff  [3];
   logic [NUM_W-1:0] num_in [3];
   logic [CH_W-1:0]  q0_in  [3];
   logic [CH_W-1:0]  q_fix  [3];

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    req_xfer;
   logic    out_free;

   assign req_stall = state_ff != ST_IDLE;
   assign req_xfer  = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff    <= FG_RESET;
         bg_ff    <= BG_RESET;
         cx_ff    <= CX_RESET;
         cy_ff    <= CY_RESET;
         limit_ff <= LIMIT_RESET;
         step_ff  <= STEP_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FOREGROUND: fg_ff    <= csr_wdata;
            CSR_BACKGROUND: bg_ff    <= csr_wdata;
            CSR_CENTER_X:   cx_ff    <= csr_wdata[X_W-1:0];
            CSR_CENTER_Y:   cy_ff    <= csr_wdata[Y_W-1:0];
            CSR_RING_LIMIT: limit_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_RING_STEP:  step_ff  <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // ring radius
   assign radius_sum = {radius_ff[RADIUS_W-1], radius_ff}
                     + $signed({{(RADIUS_W + 1 - STEP_W){1'b0}}, step_ff});

   always_comb begin
      radius_in = radius_ff;
      if (req_xfer && req_data.op == OP_TICK) begin
         if (radius_sum >= $signed({{(RADIUS_W + 1 - LIMIT_W){1'b0}}, limit_ff})) begin
            radius_in = -RADIUS_W'(BAND);
         end else begin
            radius_in = radius_sum[RADIUS_W-1:0];
         end
      end
   end

   // shared square unit
   assign mul_op  = (state_ff == ST_SQ_X) ? ax_ff : X_W'(ay_ff);
   assign mul_out = mul_op * mul_op;

   rrlb_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (RADICAND_W'(sq_ff) << (2 * FRAC_BITS)),
      .result   (root_res)
   );

   // distance minus radius
   assign diff = $signed({{(DIFF_W - ROOT_W){1'b0}}, root_res.root})
               - {{(DIFF_W - RADIUS_W){radius_ff[RADIUS_W-1]}}, radius_ff};
   assign mag      = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
   assign band_hit = mag <= DIFF_W'(BAND);

   // blend lanes: num = fg*band + (bg - fg)*a, then num / band
   always_comb begin
      logic [CH_W-1:0]         fg_ch;
      logic [CH_W-1:0]         bg_ch;
      logic [CH_W:0]           d9;
      logic signed [PROD_W-1:0] d_ext;
      logic signed [PROD_W-1:0] a_ext;
      logic signed [PROD_W-1:0] base;
      logic signed [PROD_W-1:0] sum;
      logic [QPROD_W-1:0]      qprod;
      logic [NUM_W-1:0]        rem;
      for (int i = 0; i < 3; i++) begin
         fg_ch = fg_ff[CH_W*(2-i) +: CH_W];
         bg_ch = bg_ff[CH_W*(2-i) +: CH_W];
         d9    = {1'b0, bg_ch} - {1'b0, fg_ch};
         d_ext = {{(PROD_W - CH_W - 1){d9[CH_W]}}, d9};
         a_ext = $signed({{(PROD_W - BAND_W){1'b0}}, a_ff});
         base  = $signed(PROD_W'(fg_ch) * PROD_W'(BAND));
         sum   = base + d_ext * a_ext;
         num_in[i] = sum[NUM_W-1:0];
         qprod = QPROD_W'(num_ff[i]) * QPROD_W'(RECIP);
         q0_in[i] = qprod[NUM_W +: CH_W];
         rem = num_ff[i] - NUM_W'(NUM_W'(q0_ff[i]) * NUM_W'(BAND));
         q_fix[i] = q0_ff[i] + CH_W'(rem >= NUM_W'(BAND));
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      root_start   = 1'b0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_data.op == OP_KEY) begin
               state_in = ST_SQ_X;
            end
         end
         ST_SQ_X:    state_in = ST_SQ_Y;
         ST_SQ_Y:    state_in = ST_ROOT_GO;
         ST_ROOT_GO: begin
            root_start = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_res.done) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: state_in = ST_MIX;
         ST_MIX:  state_in = ST_QUOT;
         ST_QUOT: state_in = ST_FIX;
         ST_FIX: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radius_ff    <= -RADIUS_W'(BAND);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         ax_ff <= (req_data.key_x >= cx_ff) ? req_data.key_x - cx_ff
                                            : cx_ff - req_data.key_x;
         ay_ff <= (req_data.key_y >= cy_ff) ? req_data.key_y - cy_ff
                                            : cy_ff - req_data.key_y;
      end
      if (state_ff == ST_SQ_X) begin
         sq_ff <= SUM_W'(mul_out);
      end
      if (state_ff == ST_SQ_Y) begin
         sq_ff <= sq_ff + SUM_W'(mul_out);
      end
      if (state_ff == ST_DIFF) begin
         in_band_ff <= band_hit;
         a_ff       <= band_hit ? mag[BAND_W-1:0] : BAND_W'(BAND);
      end
      for (int i = 0; i < 3; i++) begin
         if (state_ff == ST_MIX) begin
            num_ff[i] <= num_in[i];
         end
         if (state_ff == ST_QUOT) begin
            q0_ff[i] <= q0_in[i];
         end
      end
      if (state_ff == ST_FIX && out_free) begin
         rsp_data_ff.red     <= q_fix[0];
         rsp_data_ff.green   <= q_fix[1];
         rsp_data_ff.blue    <= q_fix[2];
         rsp_data_ff.in_band <= in_band_ff;
      end
   end

endmodule

`default_nettype wire

FILE: sv/rrlb_checker.sv
// Port-level checks for the radial ripple LED blend top level, and its bind.
// Depends on rrlb_pkg and radial_ripple_led_blend.
`default_nettype none

module rrlb_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_stall,
   input wire rrlb_pkg::req_type              req_data,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire rrlb_pkg::rsp_type              rsp_data
);
   import rrlb_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   // a key transfer closes the input until its result is built
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.op == OP_KEY |=> req_stall)
      else $error("input open right after a key transfer");

   // a tick is done in its own cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.op == OP_TICK |=> !req_stall)
      else $error("input closed after a tick");

   // a result never appears while the input is still open
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a key in progress");

   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("reset did not clear the channels");

endmodule

bind radial_ripple_led_blend rrlb_checker u_rrlb_checker (.*);

`default_nettype wire

FILE: verif/tb_radial_ripple_led_blend.sv
// Testbench for radial_ripple_led_blend: directed and random key and tick transfers,
// predicted ring colors checked against every rsp transfer.
// Depends on rrlb_pkg and the radial_ripple_led_blend RTL.
`default_nettype none

module tb_radial_ripple_led_blend;
   import rrlb_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam int LIMIT_CYCLES = 300000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS = 113;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [RGB_W-1:0]     csr_wdata = '0;

   // register and ring state as the block should hold it
   logic [RGB_W-1:0]           fg_rgb = FG_RESET;
   logic [RGB_W-1:0]           bg_rgb = BG_RESET;
   logic [X_W-1:0]             ctr_x = CX_RESET;
   logic [Y_W-1:0]             ctr_y = CY_RESET;
   logic [LIMIT_W-1:0]         wrap_limit = LIMIT_RESET;
   logic [STEP_W-1:0]          ring_step = STEP_RESET;
   logic signed [RADIUS_W-1:0] ring_radius = -RADIUS_W'(BAND);

   // copy used only to aim keys at the ring while building stimulus
   int                         plan_cx = CX_RESET;
   int                         plan_cy = CY_RESET;
   logic [LIMIT_W-1:0]         plan_limit = LIMIT_RESET;
   logic [STEP_W-1:0]          plan_step = STEP_RESET;
   logic signed [RADIUS_W-1:0] plan_radius = -RADIUS_W'(BAND);

   req_type pending_keys[$];
   rsp_type colors_due[$];
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   int      failures = 0;
   int      cycle_count = 0;
   bit      req_fired = 1'b0;

   radial_ripple_led_blend dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic logic signed [RADIUS_W-1:0] ring_next(
      input logic signed [RADIUS_W-1:0] radius,
      input logic [STEP_W-1:0] stp,
      input logic [LIMIT_W-1:0] lim);
      int sum;
      sum = radius;
      sum = sum + int'(stp);
      if (sum >= int'(lim)) begin
         return -RADIUS_W'(BAND);
      end
      return sum[RADIUS_W-1:0];
   endfunction

   function automatic logic [CH_W-1:0] channel_mix(input logic [CH_W-1:0] fg,
                                                   input logic [CH_W-1:0] bg,
                                                   input int a);
      int f, g;
      f = fg;
      g = bg;
      return CH_W'((g * a + f * (BAND - a)) / BAND);
   endfunction

   function automatic rsp_type key_color(input req_type item);
      int                  dx, dy;
      longint unsigned     radicand, root, trial;
      longint              diff;
      rsp_type             c;
      dx = int'(item.key_x) - int'(ctr_x);
      dy = int'(item.key_y) - int'(ctr_y);
      radicand = longint'(dx * dx + dy * dy) << (2 * FRAC_BITS);
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= radicand) root = trial;
      end
      diff = longint'(root) - longint'(ring_radius);
      if (diff < 0) diff = -diff;
      if (diff <= BAND) begin
         c.red     = channel_mix(fg_rgb[2*CH_W +: CH_W], bg_rgb[2*CH_W +: CH_W], int'(diff));
         c.green   = channel_mix(fg_rgb[CH_W +: CH_W], bg_rgb[CH_W +: CH_W], int'(diff));
         c.blue    = channel_mix(fg_rgb[0 +: CH_W], bg_rgb[0 +: CH_W], int'(diff));
         c.in_band = 1'b1;
      end else begin
         c.red     = bg_rgb[2*CH_W +: CH_W];
         c.green   = bg_rgb[CH_W +: CH_W];
         c.blue    = bg_rgb[0 +: CH_W];
         c.in_band = 1'b0;
      end
      return c;
   endfunction

   function automatic req_type make_key(input int x, input int y);
      req_type k;
      k.op    = OP_KEY;
      k.key_x = X_W'(x < 0 ? 0 : (x > (1 << X_W) - 1 ? (1 << X_W) - 1 : x));
      k.key_y = Y_W'(y < 0 ? 0 : (y > (1 << Y_W) - 1 ? (1 << Y_W) - 1 : y));
      return k;
   endfunction

   function automatic req_type make_tick();
      req_type k;
      k.op    = OP_TICK;
      k.key_x = X_W'($urandom());
      k.key_y = Y_W'($urandom());
      return k;
   endfunction

   task automatic push_item(input req_type item);
      pending_keys.push_back(item);
      if (item.op == OP_TICK) plan_radius = ring_next(plan_radius, plan_step, plan_limit);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [RGB_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic wait_idle();
      // handshake values are settled at the rising edge
      @(posedge clock);
      while (pending_keys.size() != 0 || req_valid || req_stall || rsp_valid
             || colors_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic apply_settings(input int fg, input int bg, input int cx, input int cy,
                                 input int lim, input int stp);
      wait_idle();
      write_reg(CSR_FOREGROUND, RGB_W'(fg));
      write_reg(CSR_BACKGROUND, RGB_W'(bg));
      write_reg(CSR_CENTER_X, RGB_W'(($urandom() << X_W) | cx));
      write_reg(CSR_CENTER_Y, RGB_W'(($urandom() << Y_W) | cy));
      write_reg(CSR_RING_LIMIT, RGB_W'(($urandom() << LIMIT_W) | lim));
      write_reg(CSR_RING_STEP, RGB_W'(($urandom() << STEP_W) | stp));
      // unmapped indexes must not disturb anything
      write_reg(CSR_SPARE_LO, RGB_W'($urandom()));
      write_reg(CSR_SPARE_HI, RGB_W'($urandom()));
      plan_cx    = cx;
      plan_cy    = cy;
      plan_limit = LIMIT_W'(lim);
      plan_step  = STEP_W'(stp);
      @(posedge clock);
   endtask

   task automatic random_phase(input int count);
      int pick, reach, ky;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            push_item(make_tick());
         end else if (pick < 60) begin
            // aim near the current ring
            reach = (int'(plan_radius) >>> FRAC_BITS) + int'($urandom_range(0, 80)) - 40;
            if (reach < 0) reach = -reach;
            ky = plan_cy + int'($urandom_range(0, 6)) - 3;
            if ($urandom_range(0, 1)) push_item(make_key(plan_cx + reach, ky));
            else push_item(make_key(plan_cx - reach, ky));
         end else begin
            push_item(make_key($urandom_range(0, (1 << X_W) - 1),
                               $urandom_range(0, (1 << Y_W) - 1)));
         end
      end
   endtask

   task automatic check_field(input string name, input logic [CH_W-1:0] want,
                              input logic [CH_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // sender side
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_fired) begin
            if (pending_keys.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_keys.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // transfers seen at the rising edge
   always @(posedge clock) begin
      rsp_type want;
      cycle_count++;
      req_fired = !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            if (colors_due.size() == 0) begin
               $error("rsp transfer with nothing expected: %h", rsp_data);
               failures++;
            end else begin
               want = colors_due.pop_front();
               check_field("red", want.red, rsp_data.red);
               check_field("green", want.green, rsp_data.green);
               check_field("blue", want.blue, rsp_data.blue);
               check_field("in_band", CH_W'(want.in_band), CH_W'(rsp_data.in_band));
            end
         end
         if (req_fired) begin
            if (req_data.op == OP_TICK) ring_radius = ring_next(ring_radius, ring_step, wrap_limit);
            else colors_due.push_back(key_color(req_data));
         end
         if (csr_we) begin
            case (csr_index)
               CSR_FOREGROUND: fg_rgb = csr_wdata;
               CSR_BACKGROUND: bg_rgb = csr_wdata;
               CSR_CENTER_X:   ctr_x = csr_wdata[X_W-1:0];
               CSR_CENTER_Y:   ctr_y = csr_wdata[Y_W-1:0];
               CSR_RING_LIMIT: wrap_limit = csr_wdata[LIMIT_W-1:0];
               CSR_RING_STEP:  ring_step = csr_wdata[STEP_W-1:0];
               default: ;
            endcase
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) @(posedge clock);
      $display("tb_radial_ripple_led_blend failed");
      $finish;
   end

   initial begin
      int lim_lo, step_hi;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: key on the centre sits on the band edge, then field corners
      push_item(make_key(plan_cx, plan_cy));
      push_item(make_key(0, 0));
      push_item(make_key(511, 255));
      push_item(make_key(0, 255));
      push_item(make_key(511, 0));

      // ring at zero, half blend, band edge on both sides
      apply_settings('hFF8000, 'h0040FF, 100, 100, 32767, 2304);
      push_item(make_key(100, 100));
      push_item(make_tick());
      push_item(make_key(100, 100));
      push_item(make_key(118, 100));
      push_item(make_key(136, 100));
      push_item(make_key(137, 100));
      push_item(make_tick());
      push_item(make_key(100, 100));

      // limit lowered below the radius wraps at once; zero step holds the ring
      apply_settings('h00FF00, 'hFF00FF, 100, 100, 0, 0);
      push_item(make_tick());
      push_item(make_key(100, 100));
      push_item(make_tick());
      push_item(make_key(101, 100));

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            1: apply_settings('h000000, 'hFFFFFF, 0, 0, 0, 0);
            2: apply_settings('hFFFFFF, 'h000000, 511, 255, 32767, 4095);
            default: begin
               lim_lo  = (p % 2 == 1) ? 8000 : 0;
               step_hi = (p % 2 == 1) ? 600 : 4095;
               apply_settings($urandom_range(0, 'hFFFFFF), $urandom_range(0, 'hFFFFFF),
                              $urandom_range(0, 511), $urandom_range(0, 255),
                              $urandom_range(lim_lo, 32767), $urandom_range(0, step_hi));
            end
         endcase
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 79; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 79; end
            default: begin send_idle_pct = 6; stall_pct = 6; end
         endcase
         random_phase(PHASE_ITEMS);
      end

      wait_idle();
      if (failures == 0 && colors_due.size() == 0) begin
         $display("tb_radial_ripple_led_blend passed");
      end else begin
         $display("tb_radial_ripple_led_blend failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
sv/rrlb_pkg.sv
sv/rrlb_sqrt.sv
sv/radial_ripple_led_blend.sv
sv/rrlb_checker.sv
verif/tb_radial_ripple_led_blend.sv
